// ===== src/page_allocator_refcount_core_defines.svh =====
// Assertion macros used by the page allocator controller.
`ifndef PAGE_ALLOCATOR_REFCOUNT_CORE_DEFINES_SVH
`define PAGE_ALLOCATOR_REFCOUNT_CORE_DEFINES_SVH

`ifndef NO_ASSERTIONS
// Clocked check, disabled while reset is high
`define PGA_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// Clocked check that also holds through reset
`define PGA_ASSERT_ALWAYS(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define PGA_ASSERT(lbl, clk, rst, prop, msg)
`define PGA_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif

`endif

// ===== src/pgalloc_pkg.sv =====
package pgalloc_pkg;

   // Default geometry
   localparam int NUM_PAGES_DEF  = 32768;
   localparam int PAGE_BYTES_DEF = 4096;

   // Fixed field widths
   localparam int ADDR_W   = 27;
   localparam int PG_W     = 16;
   localparam int CNT_W    = 8;
   localparam int FUNC_W   = 2;
   localparam int STATUS_W = 3;

   // Link value that ends the free list
   localparam logic [PG_W-1:0] EMPTY_MARK = '1;
   localparam logic [CNT_W-1:0] CNT_MAX   = '1;

   typedef enum logic [FUNC_W-1:0] {
      FUNC_ALLOC  = 2'd0,
      FUNC_FREE   = 2'd1,
      FUNC_ADDREF = 2'd2,
      FUNC_INIT   = 2'd3
   } func_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK       = 3'd0,
      ST_EMPTY    = 3'd1,
      ST_BADADDR  = 3'd2,
      ST_ZERO     = 3'd3,
      ST_OVERFLOW = 3'd4
   } status_type;

   // Write enables of the link and count memories
   typedef struct packed {
      logic link;
      logic count;
   } mem_we_type;

endpackage

// ===== src/pgalloc_mem.sv =====
module pgalloc_mem
   import pgalloc_pkg::*;
#(
   parameter int NUM_PAGES = NUM_PAGES_DEF
)(
   input  logic                         clock,
   input  logic                         rd_en,
   input  logic [$clog2(NUM_PAGES)-1:0] rd_idx,
   output logic [PG_W-1:0]              link_rd,
   output logic [CNT_W-1:0]             count_rd,
   input  mem_we_type                   we,
   input  logic [$clog2(NUM_PAGES)-1:0] wr_idx,
   input  logic [PG_W-1:0]              link_wd,
   input  logic [CNT_W-1:0]             count_wd
);

   logic [PG_W-1:0]  link_mem  [NUM_PAGES];
   logic [CNT_W-1:0] count_mem [NUM_PAGES];

   // Write ports
   always_ff @(posedge clock) begin
      if (we.link) begin
         link_mem[wr_idx] <= link_wd;
      end
      if (we.count) begin
         count_mem[wr_idx] <= count_wd;
      end
   end

   // Registered read of both memories at one index
   always_ff @(posedge clock) begin
      if (rd_en) begin
         link_rd  <= link_mem[rd_idx];
         count_rd <= count_mem[rd_idx];
      end
   end

endmodule

// ===== src/pgalloc_ctrl.sv =====
`include "page_allocator_refcount_core_defines.svh"

module pgalloc_ctrl
   import pgalloc_pkg::*;
#(
   parameter int NUM_PAGES  = NUM_PAGES_DEF,
   parameter int PAGE_BYTES = PAGE_BYTES_DEF
)(
   input  logic                         clock,
   input  logic                         reset,
   input  logic [PG_W-1:0]              first_page,
   input  logic                         req_tvalid,
   output logic                         req_tready,
   input  logic [31:0]                  req_tdata,
   input  logic [FUNC_W-1:0]            req_tuser,
   output logic                         rsp_tvalid,
   input  logic                         rsp_tready,
   output logic [31:0]                  rsp_tdata,
   output logic [STATUS_W-1:0]          rsp_tuser,
   output logic                         mem_rd_en,
   output logic [$clog2(NUM_PAGES)-1:0] mem_rd_idx,
   input  logic [PG_W-1:0]              mem_link_rd,
   input  logic [CNT_W-1:0]             mem_count_rd,
   output mem_we_type                   mem_we,
   output logic [$clog2(NUM_PAGES)-1:0] mem_wr_idx,
   output logic [PG_W-1:0]              mem_link_wd,
   output logic [CNT_W-1:0]             mem_count_wd
);

   localparam int IDX_W = $clog2(NUM_PAGES);
   localparam int SHIFT = $clog2(PAGE_BYTES);
   localparam int PGN_W = ADDR_W - SHIFT;

   typedef enum logic [2:0] {
      S_IDLE = 3'b001,
      S_EXEC = 3'b010,
      S_INIT = 3'b100
   } state_type;

   state_type           state_ff, state_in;
   logic [PG_W-1:0]     head_ff, head_in;
   func_type            func_ff, func_in;
   logic [IDX_W-1:0]    idx_ff, idx_in;
   logic                bad_ff, bad_in;
   logic [IDX_W-1:0]    walk_ff, walk_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [ADDR_W-1:0]   rsp_addr_ff, rsp_addr_in;
   status_type          rsp_status_ff, rsp_status_in;

   logic [ADDR_W-1:0]   req_addr;
   logic [PGN_W-1:0]    req_page;
   logic                req_aligned;
   logic                req_in_range;
   logic                accept;
   logic                out_free;
   logic                head_ok;
   logic                first_ok;

   // Decode the incoming request
   assign req_addr     = req_tdata[ADDR_W-1:0];
   assign req_page     = req_addr[ADDR_W-1:SHIFT];
   assign req_aligned  = (req_addr[SHIFT-1:0] == '0);
   assign req_in_range = (32'(req_page) < 32'(NUM_PAGES)) &&
                         (32'(req_page) >= 32'(first_page));
   assign first_ok     = (32'(first_page) < 32'(NUM_PAGES));
   assign head_ok      = (32'(head_ff) < 32'(NUM_PAGES));

   assign req_tready = (state_ff == S_IDLE);
   assign accept     = req_tvalid && req_tready;
   assign out_free   = !rsp_valid_ff || rsp_tready;

   // Read the entry of the page that the request names, or of the list head for allocate
   assign mem_rd_en  = accept;
   assign mem_rd_idx = idx_in;

   always_comb begin
      state_in      = state_ff;
      head_in       = head_ff;
      func_in       = func_ff;
      idx_in        = idx_ff;
      bad_in        = bad_ff;
      walk_in       = walk_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      rsp_addr_in   = rsp_addr_ff;
      rsp_status_in = rsp_status_ff;
      mem_we        = '0;
      mem_wr_idx    = idx_ff;
      mem_link_wd   = head_ff;
      mem_count_wd  = '0;

      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               func_in = func_type'(req_tuser);
               bad_in  = !(req_aligned && req_in_range);
               if (func_type'(req_tuser) == FUNC_ALLOC) begin
                  idx_in = head_ff[IDX_W-1:0];
               end else begin
                  idx_in = IDX_W'(req_page);
               end
               state_in = S_EXEC;
               // Initialize starts an empty list and walks the managed pages
               if (func_type'(req_tuser) == FUNC_INIT) begin
                  head_in = EMPTY_MARK;
                  walk_in = IDX_W'(first_page);
                  if (first_ok) begin
                     state_in = S_INIT;
                  end
               end
            end
         end

         S_INIT: begin
            // Push one page per cycle with a zero count
            mem_we.link  = 1'b1;
            mem_we.count = 1'b1;
            mem_wr_idx   = walk_ff;
            mem_count_wd = '0;
            head_in      = PG_W'(walk_ff);
            walk_in      = walk_ff + 1'b1;
            if (walk_ff == IDX_W'(NUM_PAGES - 1)) begin
               state_in = S_EXEC;
            end
         end

         S_EXEC: begin
            // Hold until the output register is free, then modify and answer
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_addr_in   = '0;
               rsp_status_in = ST_OK;
               state_in      = S_IDLE;
               case (func_ff)
                  FUNC_ALLOC: begin
                     if (!head_ok) begin
                        rsp_status_in = ST_EMPTY;
                     end else begin
                        head_in      = mem_link_rd;
                        mem_we.count = 1'b1;
                        mem_count_wd = CNT_W'(1);
                        rsp_addr_in  = ADDR_W'({idx_ff, {SHIFT{1'b0}}});
                     end
                  end
                  FUNC_FREE: begin
                     if (bad_ff) begin
                        rsp_status_in = ST_BADADDR;
                     end else if (mem_count_rd == '0) begin
                        rsp_status_in = ST_ZERO;
                     end else begin
                        mem_we.count = 1'b1;
                        mem_count_wd = mem_count_rd - 1'b1;
                        // Last reference gone: push the page
                        if (mem_count_rd == CNT_W'(1)) begin
                           mem_we.link = 1'b1;
                           head_in     = PG_W'(idx_ff);
                        end
                     end
                  end
                  FUNC_ADDREF: begin
                     if (bad_ff) begin
                        rsp_status_in = ST_BADADDR;
                     end else if (mem_count_rd == '0) begin
                        rsp_status_in = ST_ZERO;
                     end else if (mem_count_rd == CNT_MAX) begin
                        rsp_status_in = ST_OVERFLOW;
                     end else begin
                        mem_we.count = 1'b1;
                        mem_count_wd = mem_count_rd + 1'b1;
                     end
                  end
                  default: begin
                     rsp_status_in = ST_OK;
                  end
               endcase
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         head_ff      <= EMPTY_MARK;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         head_ff      <= head_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Request and result payload
   always_ff @(posedge clock) begin
      func_ff       <= func_in;
      idx_ff        <= idx_in;
      bad_ff        <= bad_in;
      walk_ff       <= walk_in;
      rsp_addr_ff   <= rsp_addr_in;
      rsp_status_ff <= rsp_status_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = 32'(rsp_addr_ff);
   assign rsp_tuser  = rsp_status_ff;

   `PGA_ASSERT(a_accept_leaves_idle, clock, reset, accept |=> (state_ff != S_IDLE), "request accepted but sequencer stayed idle")
   `PGA_ASSERT(a_no_write_idle, clock, reset, (mem_we.link || mem_we.count) |-> (state_ff != S_IDLE), "memory written while idle")
   `PGA_ASSERT(a_addr_zero_on_error, clock, reset, (rsp_valid_ff && (rsp_status_ff != ST_OK)) |-> (rsp_addr_ff == '0), "page address nonzero on failed request")
   `PGA_ASSERT(a_init_exits_exec, clock, reset, (state_ff == S_INIT) |=> ((state_ff == S_INIT) || (state_ff == S_EXEC)), "init walk left for a wrong state")
   `PGA_ASSERT_ALWAYS(a_reset_idle, clock, reset |=> ((state_ff == S_IDLE) && !rsp_valid_ff), "reset did not clear the sequencer")

endmodule

// ===== src/page_allocator_refcount_core.sv =====
// Page allocator with a LIFO free list and an 8-bit reference count per page.
// Request channel (req_): req_tuser carries the operation (allocate, free,
// add reference, initialize), req_tdata the page byte offset used by free and
// add reference. Result channel (rsp_): one result per request, rsp_tdata the
// allocated page offset (zero unless an allocation succeeds), rsp_tuser the
// status. csr_we/csr_wdata write first_page; the user must write it only while
// no request is in work, as the block itself does not enforce this. Allocate,
// free and add reference read the link and count memories when the request is
// taken and write them back once the output register is free; no new request
// is taken until the result is registered. Initialize writes one page per cycle
// through the memories, then answers; it writes no page if first_page is at or
// above NUM_PAGES. PAGE_BYTES must be a power of two.
// Reset empties the free list and idles the sequencer; memory contents stay
// undefined until an initialize. A stalled result waits in the output
// register while the next request is still taken; that request then holds in
// its write-back cycle until the output register frees.
module page_allocator_refcount_core
   import pgalloc_pkg::*;
#(
   parameter int NUM_PAGES  = NUM_PAGES_DEF,
   parameter int PAGE_BYTES = PAGE_BYTES_DEF
)(
   input  logic                clock,
   input  logic                reset,
   input  logic                csr_we,
   input  logic [PG_W-1:0]     csr_wdata,   // first_page
   input  logic                req_tvalid,
   output logic                req_tready,
   input  logic [31:0]         req_tdata,   // [26:0] addr, [31:27] zero
   input  logic [FUNC_W-1:0]   req_tuser,   // [1:0] func
   output logic                rsp_tvalid,
   input  logic                rsp_tready,
   output logic [31:0]         rsp_tdata,   // [26:0] page_addr, [31:27] zero
   output logic [STATUS_W-1:0] rsp_tuser    // [2:0] status
);

   localparam int IDX_W = $clog2(NUM_PAGES);

   logic [PG_W-1:0]  first_page_ff;
   logic             mem_rd_en;
   logic [IDX_W-1:0] mem_rd_idx;
   logic [PG_W-1:0]  mem_link_rd;
   logic [CNT_W-1:0] mem_count_rd;
   mem_we_type       mem_we;
   logic [IDX_W-1:0] mem_wr_idx;
   logic [PG_W-1:0]  mem_link_wd;
   logic [CNT_W-1:0] mem_count_wd;

   // Hold the lowest managed page index
   always_ff @(posedge clock) begin
      if (reset) begin
         first_page_ff <= '0;
      end else if (csr_we) begin
         first_page_ff <= csr_wdata;
      end
   end

   pgalloc_ctrl #(
      .NUM_PAGES  (NUM_PAGES),
      .PAGE_BYTES (PAGE_BYTES)
   ) u_ctrl (
      .clock        (clock),
      .reset        (reset),
      .first_page   (first_page_ff),
      .req_tvalid   (req_tvalid),
      .req_tready   (req_tready),
      .req_tdata    (req_tdata),
      .req_tuser    (req_tuser),
      .rsp_tvalid   (rsp_tvalid),
      .rsp_tready   (rsp_tready),
      .rsp_tdata    (rsp_tdata),
      .rsp_tuser    (rsp_tuser),
      .mem_rd_en    (mem_rd_en),
      .mem_rd_idx   (mem_rd_idx),
      .mem_link_rd  (mem_link_rd),
      .mem_count_rd (mem_count_rd),
      .mem_we       (mem_we),
      .mem_wr_idx   (mem_wr_idx),
      .mem_link_wd  (mem_link_wd),
      .mem_count_wd (mem_count_wd)
   );

   pgalloc_mem #(
      .NUM_PAGES (NUM_PAGES)
   ) u_mem (
      .clock    (clock),
      .rd_en    (mem_rd_en),
      .rd_idx   (mem_rd_idx),
      .link_rd  (mem_link_rd),
      .count_rd (mem_count_rd),
      .we       (mem_we),
      .wr_idx   (mem_wr_idx),
      .link_wd  (mem_link_wd),
      .count_wd (mem_count_wd)
   );

endmodule
